/* hw/rtl/vfd_pkg.sv */
// Shared types and constants for the varint and fixed-field decoder.
// Holds field kind codes, status codes, the queue record and register map.
// No dependencies.
`default_nettype none

package vfd_pkg;

	// Field kinds carried with every byte.
	typedef enum logic [3:0] {
		K_VARINT   = 4'd0,
		K_VARLONG  = 4'd1,
		K_SVARINT  = 4'd2,
		K_SVARLONG = 4'd3,
		K_U8       = 4'd4,
		K_U16      = 4'd5,
		K_U32      = 4'd6,
		K_U64      = 4'd7,
		K_S8       = 4'd8,
		K_S16      = 4'd9,
		K_S32      = 4'd10,
		K_S64      = 4'd11,
		K_BOOL     = 4'd12,
		K_LENGTH   = 4'd13
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERRUN  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam int unsigned DATA_W      = 64;
	localparam int unsigned USED_W      = 4;
	localparam int unsigned VARINT_LAST = 9;

	// Register map.
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_STRING_LENGTH = 3'd0;
	localparam logic [APB_DATA_W-1:0] MAX_STRING_LENGTH_RST  = 32'd1048576;

	// Queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One finished field as handed from the front to the back.
	typedef struct packed {
		logic [DATA_W-1:0] acc;
		kind_t             kind;
		status_t           status;
		logic [USED_W-1:0] used;
	} field_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/varint_and_fixed_field_decoder.sv */
// Streaming decoder for LEB128 varints (32/64-bit, optional zigzag), big-endian
// fixed fields, booleans and length prefixes. Takes one byte per cycle: the
// input is stalled only when the two-entry queue between the front part and
// the back part's output register is full, so with out_stall low the block
// sustains one byte per cycle with no gaps. The byte that finishes a field is
// decoded by the front into the queue, then its result goes to the output
// register. Errors are sticky until a byte with buffer_start.
// Depends on vfd_pkg and the vfd_regs, vfd_front, vfd_queue and vfd_back modules.
`default_nettype none

module varint_and_fixed_field_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Byte input channel.
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       data_byte,
	input  wire logic [3:0]                       kind,
	input  wire logic                             buffer_start,
	input  wire logic                             buffer_end,
	// Result channel.
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [vfd_pkg::DATA_W-1:0]       field_value,
	output logic      [1:0]                       status,
	output logic      [vfd_pkg::USED_W-1:0]       bytes_used,
	// Configuration port.
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [vfd_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [vfd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [vfd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);
	import vfd_pkg::*;

	logic [APB_DATA_W-1:0] max_len;
	logic                  in_fire;
	logic                  push, pop, q_not_empty, q_full;
	field_rec_t            wr_rec, rd_rec;

	// A request is taken whenever the queue has room.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	vfd_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.max_string_length (max_len)
	);

	vfd_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_fire           (in_fire),
		.data_byte         (data_byte),
		.kind              (kind),
		.buffer_start      (buffer_start),
		.buffer_end        (buffer_end),
		.max_string_length (max_len),
		.push              (push),
		.rec               (wr_rec)
	);

	vfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.pop       (pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.rd_rec    (rd_rec)
	);

	vfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rec       (rd_rec),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_value (field_value),
		.status      (status),
		.bytes_used  (bytes_used)
	);

endmodule

`default_nettype wire

/* hw/rtl/vfd_regs.sv */
// Configuration register file for the decoder, reached over an APB-style port.
// Depends on vfd_pkg for the register map.
`default_nettype none

module vfd_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vfd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [vfd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [vfd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output logic      [vfd_pkg::APB_DATA_W-1:0]  max_string_length
);
	import vfd_pkg::*;

	logic [APB_DATA_W-1:0] max_len_q;
	logic                  hit;
	logic                  wr_en;

	// Word decode ignores the byte offset within the word.
	assign hit   = (paddr[APB_ADDR_W-1:2] == ADDR_MAX_STRING_LENGTH[APB_ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && hit;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_STRING_LENGTH_RST;
		end else if (wr_en) begin
			max_len_q <= pwdata;
		end
	end

	// Reads return the register, other words read as zero.
	assign prdata            = hit ? max_len_q : '0;
	assign pready            = 1'b1;
	assign max_string_length = max_len_q;

endmodule

`default_nettype wire

/* hw/rtl/vfd_front.sv */
// Front part of the decoder: accepts bytes, tracks the open field and errors,
// and pushes one record per finished or failed field. Depends on vfd_pkg.
`default_nettype none

module vfd_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_fire,
	input  wire logic [7:0]                     data_byte,
	input  wire logic [3:0]                     kind,
	input  wire logic                           buffer_start,
	input  wire logic                           buffer_end,
	input  wire logic [vfd_pkg::APB_DATA_W-1:0] max_string_length,
	output logic                                push,
	output vfd_pkg::field_rec_t                 rec
);
	import vfd_pkg::*;

	logic [USED_W-1:0] idx_q;
	logic [DATA_W-1:0] acc_q;
	kind_t             kind_q;
	status_t           sticky_q;

	logic [USED_W-1:0] eff_idx, nxt_idx;
	logic [DATA_W-1:0] eff_acc, nxt_acc, acc_new, var_bits;
	status_t           eff_sticky, nxt_sticky;
	kind_t             fk, nxt_kind;
	logic              first, kind_ok, is_var, done, emit;
	logic [USED_W:0]   used;
	logic [5:0]        shamt;
	logic [USED_W-1:0] need;
	status_t           st;

	// Decode one byte against the open field.
	always_comb begin
		eff_sticky = buffer_start ? ST_OK : sticky_q;
		eff_idx    = buffer_start ? '0 : idx_q;
		eff_acc    = buffer_start ? '0 : acc_q;
		first      = (eff_idx == '0);
		kind_ok    = (kind <= K_LENGTH);
		fk         = first ? kind_t'(kind) : kind_q;
		used       = {1'b0, eff_idx} + 1'b1;
		shamt      = 6'({2'b00, eff_idx} * 6'd7);
		var_bits   = {57'd0, data_byte[6:0]} << shamt;
		need       = USED_W'(1) << fk[1:0];
		is_var     = (fk <= K_SVARLONG) || (fk == K_LENGTH);

		nxt_idx    = eff_idx;
		nxt_acc    = eff_acc;
		nxt_kind   = kind_q;
		nxt_sticky = eff_sticky;
		emit       = 1'b0;
		st         = ST_OK;
		acc_new    = eff_acc;
		done       = 1'b0;

		if ((eff_sticky == ST_OK) && !(first && !kind_ok)) begin
			if (first) begin
				nxt_kind = kind_t'(kind);
			end
			// Accumulate according to the field kind.
			if (is_var) begin
				acc_new = eff_acc | var_bits;
				done    = !data_byte[7] || (eff_idx >= USED_W'(VARINT_LAST));
			end else if (fk <= K_S64) begin
				acc_new = {eff_acc[DATA_W-9:0], data_byte};
				done    = (used >= {1'b0, need});
			end else begin
				acc_new = {56'd0, data_byte};
				done    = 1'b1;
			end

			// Completion and error checks, earliest check first.
			priority if (is_var && (eff_idx >= USED_W'(VARINT_LAST)) &&
					(data_byte > 8'h01)) begin
				emit = 1'b1;
				st   = ST_OVERFLOW;
			end else if (!done) begin
				if (buffer_end) begin
					emit = 1'b1;
					st   = ST_OVERRUN;
				end
			end else if (((fk == K_VARINT) || (fk == K_SVARINT)) &&
					(acc_new[DATA_W-1:32] != '0)) begin
				emit = 1'b1;
				st   = ST_OVERFLOW;
			end else if ((fk == K_LENGTH) &&
					(acc_new > {32'd0, max_string_length})) begin
				emit = 1'b1;
				st   = ST_OVERFLOW;
			end else begin
				emit = 1'b1;
				st   = ST_OK;
			end

			if (emit) begin
				nxt_idx    = '0;
				nxt_acc    = '0;
				nxt_sticky = st;
			end else begin
				nxt_idx = used[USED_W-1:0];
				nxt_acc = acc_new;
			end
		end

		push       = in_fire && emit;
		rec.acc    = acc_new;
		rec.kind   = fk;
		rec.status = st;
		rec.used   = used[USED_W-1:0];
	end

	// Field state, updated on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			acc_q    <= '0;
			kind_q   <= K_VARINT;
			sticky_q <= ST_OK;
		end else if (in_fire) begin
			idx_q    <= nxt_idx;
			acc_q    <= nxt_acc;
			kind_q   <= nxt_kind;
			sticky_q <= nxt_sticky;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/vfd_queue.sv */
// Short queue of finished field records between the front and back parts.
// Depends on vfd_pkg for the record type and depth.
`default_nettype none

module vfd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  vfd_pkg::field_rec_t      wr_rec,
	input  wire logic                pop,
	output logic                     not_empty,
	output logic                     full,
	output vfd_pkg::field_rec_t      rd_rec
);
	import vfd_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	field_rec_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_rec    = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/vfd_back.sv */
// Back part of the decoder: turns a queued record into the final value
// (zigzag, sign extension, boolean) and holds it in the output register.
// Depends on vfd_pkg.
`default_nettype none

module vfd_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_not_empty,
	input  vfd_pkg::field_rec_t               q_rec,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [vfd_pkg::DATA_W-1:0]   field_value,
	output logic      [1:0]                   status,
	output logic      [vfd_pkg::USED_W-1:0]   bytes_used
);
	import vfd_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] value_q;
	status_t           status_q;
	logic [USED_W-1:0] used_q;
	logic [DATA_W-1:0] value;
	logic [31:0]       zz32;

	// Final value of a field; errors read as zero.
	always_comb begin
		zz32 = q_rec.acc[0] ? ~q_rec.acc[32:1] : q_rec.acc[32:1];
		unique case (q_rec.kind)
			K_SVARINT:  value = {{32{zz32[31]}}, zz32};
			K_SVARLONG: value = q_rec.acc[0] ? ~{1'b0, q_rec.acc[DATA_W-1:1]}
			                                 :  {1'b0, q_rec.acc[DATA_W-1:1]};
			K_S8:       value = {{56{q_rec.acc[7]}}, q_rec.acc[7:0]};
			K_S16:      value = {{48{q_rec.acc[15]}}, q_rec.acc[15:0]};
			K_S32:      value = {{32{q_rec.acc[31]}}, q_rec.acc[31:0]};
			K_BOOL:     value = {63'd0, (q_rec.acc != '0)};
			default:    value = q_rec.acc;
		endcase
		if (q_rec.status != ST_OK) begin
			value = '0;
		end
	end

	// Take a new record whenever the output register is free or being taken.
	assign pop = q_not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q  <= value;
			status_q <= q_rec.status;
			used_q   <= q_rec.used;
		end
	end

	assign out_valid   = valid_q;
	assign field_value = value_q;
	assign status      = status_q;
	assign bytes_used  = used_q;

endmodule

`default_nettype wire

/* tb/vfd_decode_monitor.sv */
`timescale 1ns / 100ps
// Result monitor for the varint and fixed-field decoder testbench.
// Tracks the byte, result and register ports, predicts every decoded field and
// compares it with what the block returns. Depends on vfd_pkg.

module vfd_decode_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic [3:0]                     kind,
	input  logic                           buffer_start,
	input  logic                           buffer_end,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [vfd_pkg::DATA_W-1:0]     field_value,
	input  logic [1:0]                     status,
	input  logic [vfd_pkg::USED_W-1:0]     bytes_used,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [vfd_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             fields_pending,
	output int                             fields_checked,
	output int                             error_fields
);
	import vfd_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t           st;
		logic [USED_W-1:0] used;
	} decoded_field_t;

	// Decoder state as the block should hold it.
	logic [3:0]        bytes_taken;
	logic [63:0]       partial;
	kind_t             open_kind;
	status_t           held_error;
	logic [31:0]       max_len;
	decoded_field_t    expected_fields[$];

	// Closes the open field. An error carries a zero value and is held until a
	// new buffer starts.
	task automatic close_field(input logic [63:0] v, input status_t st,
			input logic [3:0] used);
		decoded_field_t f;
		f.value = (st == ST_OK) ? v : '0;
		f.st = st;
		f.used = used;
		if (st != ST_OK)
			held_error = st;
		expected_fields.push_back(f);
		bytes_taken = '0;
		partial = '0;
	endtask

	// Takes one accepted byte and queues the field it finishes, if any.
	task automatic decode_byte(input logic [7:0] b, input logic [3:0] k,
			input logic s, input logic e);
		logic [3:0]  n;
		logic [3:0]  need;
		logic        done;
		logic [63:0] zz;
		logic [63:0] val;
		int          w;
		if (s) begin
			held_error = ST_OK;
			bytes_taken = '0;
			partial = '0;
		end
		if (held_error != ST_OK)
			return;
		if (bytes_taken == 0) begin
			if (k > K_LENGTH)
				return;
			open_kind = kind_t'(k);
			partial = '0;
		end
		n = bytes_taken + 4'd1;
		need = 4'd1;
		done = 1'b0;

		// Gather the byte: base-128 groups, big-endian octets or a single flag.
		case (open_kind)
			K_VARINT, K_VARLONG, K_SVARINT, K_SVARLONG, K_LENGTH: begin
				if (bytes_taken >= VARINT_LAST && b > 8'h01) begin
					close_field('0, ST_OVERFLOW, n);
					return;
				end
				partial = partial | ({57'd0, b[6:0]} << (7 * bytes_taken));
				done = !b[7] || bytes_taken >= VARINT_LAST;
			end
			K_BOOL: begin
				partial = {56'd0, b};
				done = 1'b1;
			end
			default: begin
				need = 4'd1 << open_kind[1:0];
				partial = {partial[55:0], b};
				done = (n >= need);
			end
		endcase

		if (!done) begin
			if (e)
				close_field('0, ST_OVERRUN, n);
			else
				bytes_taken = n;
			return;
		end

		// Turn the finished field into its 64-bit result.
		val = partial;
		case (open_kind)
			K_VARINT: begin
				if (|partial[63:32]) begin
					close_field('0, ST_OVERFLOW, n);
					return;
				end
			end
			K_SVARINT: begin
				if (|partial[63:32]) begin
					close_field('0, ST_OVERFLOW, n);
					return;
				end
				zz = partial[0] ? {32'd0, ~partial[32:1]} : (partial >> 1);
				val = {{32{zz[31]}}, zz[31:0]};
			end
			K_SVARLONG: val = partial[0] ? ~(partial >> 1) : (partial >> 1);
			K_S8, K_S16, K_S32, K_S64: begin
				w = 8 * need;
				if (w < 64 && partial[w-1])
					val = partial | (~64'd0 << w);
			end
			K_BOOL: val = {63'd0, |partial};
			K_LENGTH: begin
				if (partial > {32'd0, max_len}) begin
					close_field('0, ST_OVERFLOW, n);
					return;
				end
			end
			default: ;
		endcase
		close_field(val, ST_OK, n);
	endtask

	// Compare returned fields, then predict from the request taken this edge.
	always @(posedge clk or negedge arst_n) begin
		decoded_field_t want;
		if (!arst_n) begin
			bytes_taken = '0;
			partial = '0;
			open_kind = K_VARINT;
			held_error = ST_OK;
			max_len = MAX_STRING_LENGTH_RST;
			expected_fields.delete();
			fail_count = 0;
			fields_pending = 0;
			fields_checked = 0;
			error_fields = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_MAX_STRING_LENGTH)
				max_len = pwdata;

			if (out_valid && !out_stall) begin
				if (expected_fields.size() == 0) begin
					$display("%0t: unexpected field: value %h status %0d used %0d",
						$time, field_value, status, bytes_used);
					fail_count++;
				end else begin
					want = expected_fields.pop_front();
					if (field_value !== want.value) begin
						$display("%0t: field_value expected %h got %h",
							$time, want.value, field_value);
						fail_count++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.st, status);
						fail_count++;
					end
					if (bytes_used !== want.used) begin
						$display("%0t: bytes_used expected %0d got %0d",
							$time, want.used, bytes_used);
						fail_count++;
					end
					fields_checked++;
					if (want.st != ST_OK)
						error_fields++;
				end
			end

			if (in_valid && !in_stall)
				decode_byte(data_byte, kind, buffer_start, buffer_end);
			fields_pending = expected_fields.size();
		end
	end

endmodule

/* tb/varint_and_fixed_field_decoder_test.sv */
`timescale 1ns / 100ps
// Top of the varint and fixed-field decoder testbench: clock, reset, byte
// stream, result stall and register writes, with the verdict at the end.
// Depends on vfd_pkg, the decoder and vfd_decode_monitor.

module varint_and_fixed_field_decoder_test;
	import vfd_pkg::*;

	// Kind codes the block does not decode.
	localparam logic [3:0] K_SPARE_A = 4'd14;
	localparam logic [3:0] K_SPARE_B = 4'd15;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] kind;
		logic       bstart;
		logic       bend;
	} stream_byte_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            data_byte;
	logic [3:0]            kind;
	logic                  buffer_start;
	logic                  buffer_end;
	logic                  out_valid;
	logic                  out_stall;
	logic [DATA_W-1:0]     field_value;
	logic [1:0]            status;
	logic [USED_W-1:0]     bytes_used;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int fields_pending;
	int fields_checked;
	int error_fields;

	stream_byte_t tx_bytes[$];
	logic [31:0]  cur_max_len;
	bit           idle_on;
	bit           hold_long;
	int           bytes_offered;
	int           limits_used;

	varint_and_fixed_field_decoder dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .data_byte, .kind, .buffer_start, .buffer_end,
		.out_valid, .out_stall, .field_value, .status, .bytes_used,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	vfd_decode_monitor field_check (
		.clk, .arst_n,
		.in_valid, .in_stall, .data_byte, .kind, .buffer_start, .buffer_end,
		.out_valid, .out_stall, .field_value, .status, .bytes_used,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .fields_pending, .fields_checked, .error_fields
	);

	// Clock, 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#2_000_000;
		$display("varint_and_fixed_field_decoder_test: errors");
		$finish;
	end

	// Result side: a random stall before each result, or one long hold on request.
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (80) @(negedge clk);
				hold_long = 1'b0;
			end else begin
				gap = idle_on ? $urandom_range(0, 8) : 0;
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic add_byte(input logic [7:0] d, input logic [3:0] k,
			input logic s, input logic e);
		stream_byte_t r;
		r.data = d;
		r.kind = k;
		r.bstart = s;
		r.bend = e;
		tx_bytes.push_back(r);
	endtask

	// Later bytes of a field sometimes carry another kind, which must be ignored.
	function automatic logic [3:0] tail_kind(input logic [3:0] k);
		return ($urandom_range(0, 3) == 0) ? 4'($urandom) : k;
	endfunction

	// Base-128 encoding, optionally padded with redundant zero groups.
	task automatic add_leb(input logic [63:0] v, input int pad, input logic [3:0] k);
		logic [63:0] rest;
		logic [7:0]  grp;
		int          n;
		rest = v;
		n = 0;
		do begin
			grp = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != 0)
				grp[7] = 1'b1;
			else if (pad > 0) begin
				grp[7] = 1'b1;
				pad--;
			end
			if (n == VARINT_LAST)
				grp[7] = 1'b0;
			add_byte(grp, (n == 0) ? k : tail_kind(k), 1'b0, 1'b0);
			n++;
		end while (grp[7]);
	endtask

	// One well-formed field of the given kind with random content.
	task automatic add_field(input logic [3:0] k);
		logic [63:0] v;
		logic [7:0]  octet;
		int          w;
		case (k)
			K_VARINT, K_VARLONG, K_SVARINT, K_SVARLONG, K_LENGTH: begin
				if ($urandom_range(0, 19) == 0) begin
					// Ten groups with a tenth byte too large.
					add_byte({1'b1, 7'($urandom)}, k, 1'b0, 1'b0);
					repeat (8) add_byte({1'b1, 7'($urandom)}, tail_kind(k), 1'b0, 1'b0);
					add_byte(8'($urandom_range(2, 255)), tail_kind(k), 1'b0, 1'b0);
				end else begin
					w = $urandom_range(0, (k == K_VARINT || k == K_SVARINT) ? 36 : 64);
					v = {$urandom, $urandom};
					if (w < 64)
						v = v & ((64'd1 << w) - 64'd1);
					if ($urandom_range(0, 7) == 0)
						v = (w < 64) ? ((64'd1 << w) - 64'd1) : ~64'd0;
					// Length prefixes often land right around the limit.
					if (k == K_LENGTH && $urandom_range(0, 1) == 0)
						v = {32'd0, cur_max_len} + 64'($urandom_range(0, 2)) - 64'd1;
					add_leb(v, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, k);
				end
			end
			K_BOOL: add_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom),
					k, 1'b0, 1'b0);
			default: begin
				for (int i = 0; i < (1 << k[1:0]); i++) begin
					case ($urandom_range(0, 5))
						0: octet = 8'h00;
						1: octet = 8'hff;
						2: octet = 8'h80;
						3: octet = 8'h7f;
						default: octet = 8'($urandom);
					endcase
					add_byte(octet, (i == 0) ? k : tail_kind(k), 1'b0, 1'b0);
				end
			end
		endcase
	endtask

	// A buffer of a few fields; sometimes the last one is cut short, and
	// sometimes the buffer is left open so the next one starts mid-stream.
	task automatic add_buffer();
		int first_at;
		int field_at;
		int tail;
		first_at = tx_bytes.size();
		field_at = first_at;
		repeat ($urandom_range(1, 5)) begin
			field_at = tx_bytes.size();
			add_field(4'($urandom_range(0, 13)));
		end
		tail = tx_bytes.size() - field_at;
		if ($urandom_range(0, 6) == 0 && tail > 1)
			repeat ($urandom_range(1, tail - 1)) void'(tx_bytes.pop_back());
		tx_bytes[first_at].bstart = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 4) != 0)
			tx_bytes[tx_bytes.size() - 1].bend = 1'b1;
	endtask

	// Mostly buffers, with some bytes of random kind and framing in between.
	task automatic add_random(input int count);
		int goal;
		goal = tx_bytes.size() + count;
		while (tx_bytes.size() < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					add_byte(8'($urandom), 4'($urandom), $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0);
			end else
				add_buffer();
		end
	endtask

	// Offers every queued byte, with a random gap before each request.
	task automatic send_stream();
		stream_byte_t r;
		int           gap;
		while (tx_bytes.size() != 0) begin
			r = tx_bytes.pop_front();
			gap = idle_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			data_byte <= r.data;
			kind <= r.kind;
			buffer_start <= r.bstart;
			buffer_end <= r.bend;
			in_valid <= 1'b1;
			do @(posedge clk); while (in_stall);
			bytes_offered++;
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	// Waits until every predicted field has come back, then lets the pipeline settle.
	task automatic wait_idle();
		while (fields_pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [31:0] v);
		wait_idle();
		paddr <= ADDR_MAX_STRING_LENGTH;
		pwdata <= v;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_max_len = v;
		limits_used++;
	endtask

	initial begin
		in_valid = 1'b0;
		data_byte = '0;
		kind = '0;
		buffer_start = 1'b0;
		buffer_end = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		hold_long = 1'b0;
		cur_max_len = MAX_STRING_LENGTH_RST;
		bytes_offered = 0;
		limits_used = 1;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corner cases under the reset length limit.
		add_byte(8'h01, K_SVARINT, 1'b1, 1'b0);
		add_byte(8'hff, K_S8, 1'b0, 1'b0);
		// The kind of the first byte governs the whole field.
		add_byte(8'h80, K_S16, 1'b0, 1'b0);
		add_byte(8'h00, K_U8, 1'b0, 1'b0);
		add_byte(8'hab, K_SPARE_A, 1'b0, 1'b0);
		add_byte(8'h00, K_SPARE_B, 1'b0, 1'b0);
		add_byte(8'h07, K_BOOL, 1'b0, 1'b0);
		add_byte(8'h7f, K_VARINT, 1'b0, 1'b0);
		// A 32-bit varint one past its range, then a byte dropped while the error holds.
		add_leb(64'h1_0000_0000, 0, K_VARINT);
		add_byte(8'h05, K_U8, 1'b0, 1'b0);
		// Length prefix one above the reset limit.
		add_byte(8'h81, K_LENGTH, 1'b1, 1'b0);
		add_byte(8'h80, K_LENGTH, 1'b0, 1'b0);
		add_byte(8'h40, K_LENGTH, 1'b0, 1'b0);
		// Tenth group above one.
		add_byte(8'hff, K_SVARLONG, 1'b1, 1'b0);
		repeat (8) add_byte(8'hff, K_SVARLONG, 1'b0, 1'b0);
		add_byte(8'h02, K_SVARLONG, 1'b0, 1'b0);
		// Buffer ends inside a four-byte field.
		add_byte(8'h12, K_U32, 1'b1, 1'b0);
		add_byte(8'h34, K_U32, 1'b0, 1'b1);
		add_random(140);
		send_stream();

		// No idling at all under the smallest limit.
		write_max_len(32'd0);
		idle_on = 1'b0;
		add_random(160);
		send_stream();

		// Largest limit; the result side holds off long enough to back up the input.
		write_max_len(32'hffff_ffff);
		idle_on = 1'b1;
		hold_long = 1'b1;
		add_random(160);
		send_stream();

		write_max_len(32'd300);
		add_random(160);
		send_stream();

		write_max_len($urandom);
		add_random(160);
		send_stream();

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Offered %0d bytes under %0d length limits; %0d fields checked, %0d errors among them.",
			bytes_offered, limits_used, fields_checked, error_fields);
		if (fail_count == 0 && fields_pending == 0)
			$display("varint_and_fixed_field_decoder_test: clean");
		else
			$display("varint_and_fixed_field_decoder_test: errors");
		$finish;
	end

endmodule
